>>> sv/hexv_pkg.sv
// Shared constants, types and the arctangent table of the hexagon vertex generator.
package hexv_pkg;

    localparam int CORDIC_STEPS   = 30;
    localparam int XY_W           = 34;
    localparam int Z_W            = 32;
    localparam int TRIG_W         = 30;
    localparam int NUM_W          = 66;
    localparam int DEF_ANGLE_BITS = 16;
    localparam logic signed [XY_W-1:0]   CORDIC_GAIN  = XY_W'(652032874);
    localparam logic signed [31:0]       TWO_OVER_RT3 = 32'sd1239850262;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE     = TRIG_W'(268435456);
    localparam logic [2:0]               LAST_IDX     = 3'd6;

    typedef struct packed {
        logic                   vld;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

    function automatic logic signed [Z_W-1:0] atan_turn(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 32'sd536870912;
            1:  v = 32'sd316933406;
            2:  v = 32'sd167458907;
            3:  v = 32'sd85004756;
            4:  v = 32'sd42667331;
            5:  v = 32'sd21354465;
            6:  v = 32'sd10679838;
            7:  v = 32'sd5340245;
            8:  v = 32'sd2670163;
            9:  v = 32'sd1335087;
            10: v = 32'sd667544;
            11: v = 32'sd333772;
            12: v = 32'sd166886;
            13: v = 32'sd83443;
            14: v = 32'sd41722;
            15: v = 32'sd20861;
            16: v = 32'sd10430;
            17: v = 32'sd5215;
            18: v = 32'sd2608;
            19: v = 32'sd1304;
            20: v = 32'sd652;
            21: v = 32'sd326;
            22: v = 32'sd163;
            23: v = 32'sd81;
            24: v = 32'sd41;
            25: v = 32'sd20;
            26: v = 32'sd10;
            27: v = 32'sd5;
            28: v = 32'sd3;
            29: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/hexv_cordic_stage.sv
// One registered rotation step of the CORDIC pipeline.
module hexv_cordic_stage import hexv_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cordic i_stage,
    output t_cordic o_stage
);

    localparam logic signed [Z_W-1:0] ATAN = atan_turn(IDX);

    t_cordic r_stage;
    t_cordic n_stage;

    always_comb begin
        n_stage     = i_stage;
        if (i_stage.z >= 0) begin
            n_stage.x = i_stage.x - (i_stage.y >>> IDX);
            n_stage.y = i_stage.y + (i_stage.x >>> IDX);
            n_stage.z = i_stage.z - ATAN;
        end else begin
            n_stage.x = i_stage.x + (i_stage.y >>> IDX);
            n_stage.y = i_stage.y - (i_stage.x >>> IDX);
            n_stage.z = i_stage.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> sv/hexv_cordic.sv
// Chain of CORDIC rotation steps, one register stage per step.
module hexv_cordic import hexv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cordic i_seed,
    output t_cordic o_rot
);

    t_cordic w_chain [0:CORDIC_STEPS];

    assign w_chain[0] = i_seed;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        hexv_cordic_stage #(.IDX(g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    assign o_rot = w_chain[CORDIC_STEPS];

endmodule

>>> sv/rotated_hexagon_vertices_core.sv
// Top level: rotated hexagon vertex generator, CORDIC front end and point sequencer.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | start && !busy            | i_centre_x/y, i_width, i_height, i_angle
//  result   | o_point_valid (strobe)    | o_vertex_index, o_point_x/y, o_last_point
//
// Each item yields seven points on the single result port; busy rises after an
// accept and holds while r_gap counts down. The path from accept to the first
// point runs through the input register, 30 CORDIC steps, three multiply stages
// and two point stages. Reset is synchronous and clears only valid bits and
// counters. The receiver cannot stall, so the pipeline never holds.
module rotated_hexagon_vertices_core import hexv_pkg::*; #(
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [31:0]    i_centre_x,
    input  logic signed [31:0]    i_centre_y,
    input  logic signed [31:0]    i_width,
    input  logic signed [31:0]    i_height,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output logic                  o_point_valid,
    output logic [2:0]            o_vertex_index,
    output logic signed [31:0]    o_point_x,
    output logic signed [31:0]    o_point_y,
    output logic                  o_last_point
);

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] w;
        logic signed [31:0] h;
        logic [1:0]         quad;
    } t_payload;

    // ---------------- input throttle: no new item while r_gap counts down
    logic [2:0] r_gap;
    logic       w_acc;
    assign w_acc = start && !busy;
    assign busy  = (r_gap != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 3'd0;
        end else if (w_acc) begin
            r_gap <= LAST_IDX;
        end else if (r_gap != 3'd0) begin
            r_gap <= r_gap - 3'd1;
        end
    end

    // ---------------- input register: left-align the angle, seed the CORDIC
    logic [31:0] w_a32;
    assign w_a32 = {i_angle, (32-ANGLE_BITS)'(0)};

    t_cordic  r_seed;
    t_payload r_pay [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        r_seed.vld <= w_acc;
        r_seed.x   <= CORDIC_GAIN;
        r_seed.y   <= '0;
        r_seed.z   <= {2'b00, w_a32[29:0]};
        r_pay[0]   <= '{cx: i_centre_x, cy: i_centre_y, w: i_width, h: i_height,
                        quad: w_a32[31:30]};
        if (!i_rst_n) begin
            r_seed.vld <= 1'b0;
        end
    end

    // carry the payload alongside the rotation steps
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            r_pay[i+1] <= r_pay[i];
        end
    end

    t_cordic w_rot;
    hexv_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seed  (r_seed),
        .o_rot   (w_rot)
    );

    // ---------------- T1: round to Q1.28, clamp, quadrant map; h times 2/sqrt3
    logic signed [XY_W-1:0]   w_xr, w_yr;
    logic signed [TRIG_W-1:0] w_cq, w_sq, w_c, w_s;
    t_payload                 w_p;
    assign w_p  = r_pay[CORDIC_STEPS];
    assign w_xr = (w_rot.x + XY_W'(2)) >>> 2;
    assign w_yr = (w_rot.y + XY_W'(2)) >>> 2;

    always_comb begin
        w_cq = (w_xr > XY_W'(TRIG_ONE)) ? TRIG_ONE :
               (w_xr < -XY_W'(TRIG_ONE)) ? -TRIG_ONE : TRIG_W'(w_xr);
        w_sq = (w_yr > XY_W'(TRIG_ONE)) ? TRIG_ONE :
               (w_yr < -XY_W'(TRIG_ONE)) ? -TRIG_ONE : TRIG_W'(w_yr);
        case (w_p.quad)
            2'd0:    begin w_c = w_cq;  w_s = w_sq;  end
            2'd1:    begin w_c = -w_sq; w_s = w_cq;  end
            2'd2:    begin w_c = -w_cq; w_s = -w_sq; end
            default: begin w_c = w_sq;  w_s = -w_cq; end
        endcase
    end

    logic                     r1_vld;
    logic signed [TRIG_W-1:0] r1_c, r1_s;
    logic signed [63:0]       r1_hk;
    logic signed [31:0]       r1_w, r1_cx, r1_cy;

    always_ff @(posedge i_clk) begin
        r1_vld <= w_rot.vld;
        r1_c   <= w_c;
        r1_s   <= w_s;
        r1_hk  <= 64'(w_p.h) * 64'(TWO_OVER_RT3);
        r1_w   <= w_p.w;
        r1_cx  <= w_p.cx;
        r1_cy  <= w_p.cy;
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end
    end

    // ---------------- T2: short and long y offsets, width products
    logic signed [63:0] w_sh64, w_lg64;
    assign w_sh64 = (r1_hk + 64'sd536870912) >>> 30;
    assign w_lg64 = ((r1_hk <<< 1) + 64'sd536870912) >>> 30;

    logic                     r2_vld;
    logic signed [TRIG_W-1:0] r2_c, r2_s;
    logic signed [XY_W-1:0]   r2_sh, r2_lg;
    logic signed [63:0]       r2_wc, r2_ws;
    logic signed [31:0]       r2_cx, r2_cy;

    always_ff @(posedge i_clk) begin
        r2_vld <= r1_vld;
        r2_c   <= r1_c;
        r2_s   <= r1_s;
        r2_sh  <= XY_W'(w_sh64);
        r2_lg  <= XY_W'(w_lg64);
        r2_wc  <= 64'(r1_w) * 64'(r1_c);
        r2_ws  <= 64'(r1_w) * 64'(r1_s);
        r2_cx  <= r1_cx;
        r2_cy  <= r1_cy;
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end
    end

    // ---------------- T3: offset products; held for the whole seven-point run
    logic signed [NUM_W-1:0] r3_wc2, r3_ws2, r3_shc, r3_shs, r3_lgc, r3_lgs;
    logic signed [31:0]      r3_cx, r3_cy;

    always_ff @(posedge i_clk) begin
        if (r2_vld) begin
            r3_wc2 <= NUM_W'(r2_wc) <<< 1;
            r3_ws2 <= NUM_W'(r2_ws) <<< 1;
            r3_shc <= NUM_W'(r2_sh) * NUM_W'(r2_c);
            r3_shs <= NUM_W'(r2_sh) * NUM_W'(r2_s);
            r3_lgc <= NUM_W'(r2_lg) * NUM_W'(r2_c);
            r3_lgs <= NUM_W'(r2_lg) * NUM_W'(r2_s);
            r3_cx  <= r2_cx;
            r3_cy  <= r2_cy;
        end
    end

    // ---------------- point sequencer: step the vertex index 0..6
    // Start the run in the cycle the products land in T3, so all seven points
    // read them before the next item overwrites them.
    logic       r_act;
    logic [2:0] r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_k   <= 3'd0;
        end else if (r2_vld) begin
            r_act <= 1'b1;
            r_k   <= 3'd0;
        end else if (r_act) begin
            if (r_k == LAST_IDX) begin
                r_act <= 1'b0;
            end else begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    // P1: combine the products for this vertex (the closing point reuses vertex 0)
    logic signed [NUM_W-1:0] w_nx, w_ny;
    always_comb begin
        case (r_k)
            3'd1:    begin w_nx = r3_lgs;           w_ny = -r3_lgc;          end
            3'd2:    begin w_nx = r3_wc2 + r3_shs;  w_ny = r3_ws2 - r3_shc;  end
            3'd3:    begin w_nx = r3_wc2 - r3_shs;  w_ny = r3_shc + r3_ws2;  end
            3'd4:    begin w_nx = -r3_lgs;          w_ny = r3_lgc;           end
            3'd5:    begin w_nx = -r3_wc2 - r3_shs; w_ny = r3_shc - r3_ws2;  end
            default: begin w_nx = r3_shs - r3_wc2;  w_ny = -r3_shc - r3_ws2; end
        endcase
    end

    logic                    r4_vld;
    logic [2:0]              r4_k;
    logic signed [NUM_W-1:0] r4_nx, r4_ny;
    logic signed [31:0]      r4_cx, r4_cy;

    always_ff @(posedge i_clk) begin
        r4_vld <= r_act;
        r4_k   <= r_k;
        r4_nx  <= w_nx;
        r4_ny  <= w_ny;
        r4_cx  <= r3_cx;
        r4_cy  <= r3_cy;
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end
    end

    // P2: round, translate, saturate
    localparam int SUM_W = NUM_W - 30 + 1;
    logic signed [NUM_W-1:0] w_rx, w_ry;
    logic signed [SUM_W-1:0] w_px, w_py;
    assign w_rx = (r4_nx + NUM_W'(64'sd536870912)) >>> 30;
    assign w_ry = (r4_ny + NUM_W'(64'sd536870912)) >>> 30;
    assign w_px = SUM_W'(w_rx) + SUM_W'(r4_cx);
    assign w_py = SUM_W'(w_ry) + SUM_W'(r4_cy);

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(64'sd2147483647)) begin
            return 32'sh7FFFFFFF;
        end else if (v < -SUM_W'(64'sd2147483648)) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        o_point_valid  <= r4_vld;
        o_vertex_index <= r4_k;
        o_point_x      <= sat32(w_px);
        o_point_y      <= sat32(w_py);
        o_last_point   <= (r4_k == LAST_IDX);
        if (!i_rst_n) begin
            o_point_valid <= 1'b0;
        end
    end

    // ---------------- checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted item");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_point_valid && !o_last_point) |=> (o_point_valid &&
            o_vertex_index == $past(o_vertex_index) + 3'd1))
        else $error("point run broke before the closing point");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid |-> (o_last_point == (o_vertex_index == LAST_IDX)))
        else $error("last flag disagrees with vertex index");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench of the rotated hexagon vertex generator.
`timescale 1ns / 1ps

module tb_top;
    import hexv_pkg::*;

    localparam int  HOLD_PCT   = 22;
    localparam int  WD_LIMIT   = 4000;
    localparam int  TAIL_WAIT  = 60;
    localparam int  N_RANDOM   = 270;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] w;
        logic signed [31:0] h;
        logic [15:0]        ang;
        bit                 drain_first;  // wait for all points before sending
    } t_hex_item;

    typedef struct {
        logic [2:0]         idx;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               last;
    } t_hex_point;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] i_centre_x = '0;
    logic signed [31:0] i_centre_y = '0;
    logic signed [31:0] i_width = '0;
    logic signed [31:0] i_height = '0;
    logic [15:0] i_angle = '0;
    logic o_point_valid;
    logic [2:0] o_vertex_index;
    logic signed [31:0] o_point_x;
    logic signed [31:0] o_point_y;
    logic o_last_point;

    t_hex_item  pending_items[$];
    t_hex_point expected_points[$];
    t_hex_item  in_flight;
    int n_accepted = 0;
    int n_points = 0;
    int n_errors = 0;
    int quiet_cycles = 0;

    // Arctangent steps in units of 2^-32 turn.
    longint atan_steps[30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1
    };

    rotated_hexagon_vertices_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_centre_x     (i_centre_x),
        .i_centre_y     (i_centre_y),
        .i_width        (i_width),
        .i_height       (i_height),
        .i_angle        (i_angle),
        .o_point_valid  (o_point_valid),
        .o_vertex_index (o_vertex_index),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_last_point   (o_last_point)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Rotate the six offsets and push the seven expected points of one item.
    task automatic predict_hexagon(t_hex_item it);
        logic [31:0] a32;
        longint x, y, z, dx, dy, c0, s0, c, s, hk, sh, lg, px, py;
        longint ox[6], oy[6];
        t_hex_point p;
        int v;
        a32 = {it.ang, 16'h0};
        x = 652032874;
        y = 0;
        z = longint'(a32[29:0]);
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_steps[i];
            end else begin
                x += dx; y -= dy; z += atan_steps[i];
            end
        end
        c0 = clamp(rnd_shift(x, 2), -268435456, 268435456);
        s0 = clamp(rnd_shift(y, 2), -268435456, 268435456);
        case (a32[31:30])
            2'd0: begin c = c0;  s = s0;  end
            2'd1: begin c = -s0; s = c0;  end
            2'd2: begin c = -c0; s = -s0; end
            default: begin c = s0; s = -c0; end
        endcase
        hk = longint'(it.h) * 64'sd1239850262;
        sh = rnd_shift(hk, 30);
        lg = rnd_shift(hk * 2, 30);
        ox[0] = -2 * longint'(it.w); oy[0] = -sh;
        ox[1] = 0;                   oy[1] = -lg;
        ox[2] = 2 * longint'(it.w);  oy[2] = -sh;
        ox[3] = 2 * longint'(it.w);  oy[3] = sh;
        ox[4] = 0;                   oy[4] = lg;
        ox[5] = -2 * longint'(it.w); oy[5] = sh;
        for (int k = 0; k < 7; k++) begin
            v = (k == 6) ? 0 : k;
            px = longint'(it.cx) + rnd_shift(ox[v] * c - oy[v] * s, 30);
            py = longint'(it.cy) + rnd_shift(oy[v] * c + ox[v] * s, 30);
            p.idx = 3'(k);
            p.px = 32'(clamp(px, -64'sd2147483648, 64'sd2147483647));
            p.py = 32'(clamp(py, -64'sd2147483648, 64'sd2147483647));
            p.last = (k == 6);
            expected_points.push_back(p);
        end
    endtask

    // Driver: accept on start && !busy, then load the next item or idle.
    always @(posedge i_clk) begin
        bit taken;
        bit no_idle;
        taken = 1'b0;
        no_idle = (n_accepted >= 120 && n_accepted < 170);
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_hexagon(in_flight);
                n_accepted <= n_accepted + 1;
                taken = 1'b1;
            end
            if (!start || taken) begin
                if (pending_items.size() == 0 ||
                    (pending_items[0].drain_first &&
                     (expected_points.size() != 0 || taken)) ||
                    (!no_idle && $urandom_range(99) < HOLD_PCT)) begin
                    start <= 1'b0;
                end else begin
                    in_flight = pending_items.pop_front();
                    i_centre_x <= in_flight.cx;
                    i_centre_y <= in_flight.cy;
                    i_width    <= in_flight.w;
                    i_height   <= in_flight.h;
                    i_angle    <= in_flight.ang;
                    start      <= 1'b1;
                end
            end
        end
    end

    // Monitor: every strobed point is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_hex_point e;
        if (i_rst_n && o_point_valid) begin
            n_points <= n_points + 1;
            if (expected_points.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected point idx=%0d x=%0d y=%0d",
                             o_vertex_index, o_point_x, o_point_y);
            end else begin
                e = expected_points.pop_front();
                if (o_vertex_index !== e.idx || o_point_x !== e.px ||
                    o_point_y !== e.py || o_last_point !== e.last) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("ERROR: point exp idx=%0d x=%0d y=%0d last=%0b",
                                 e.idx, e.px, e.py, e.last);
                        $display("       got idx=%0d x=%0d y=%0d last=%0b",
                                 o_vertex_index, o_point_x, o_point_y, o_last_point);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with neither an accepted item nor a point.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_point_valid || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("ERROR: watchdog expired, %0d points outstanding",
                     expected_points.size());
            $display("** rotated_hexagon_vertices_core: FAILED **");
            $finish;
        end
    end

    function automatic t_hex_item mk(logic signed [31:0] cx, logic signed [31:0] cy,
                                     logic signed [31:0] w, logic signed [31:0] h,
                                     logic [15:0] ang);
        t_hex_item it;
        it.cx = cx; it.cy = cy; it.w = w; it.h = h; it.ang = ang;
        it.drain_first = 1'b0;
        return it;
    endfunction

    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'(int'($urandom_range(65536 * 200)) - 65536 * 100);
            default: return 32'(int'($urandom_range(65536 * 40)) - 65536 * 20);
        endcase
    endfunction

    initial begin
        t_hex_item it;
        // Directed: quadrant edges, extreme sizes, mirrored shapes, saturation.
        pending_items.push_back(mk(0, 0, 32'sh0001_0000, 32'sh0001_0000, 16'h0000));
        pending_items.push_back(mk(0, 0, 32'sh0001_0000, 32'sh0001_0000, 16'h4000));
        pending_items.push_back(mk(0, 0, 32'sh0001_0000, 32'sh0001_0000, 16'h8000));
        pending_items.push_back(mk(0, 0, 32'sh0001_0000, 32'sh0001_0000, 16'hC000));
        pending_items.push_back(mk(0, 0, 32'sh0001_0000, 32'sh0001_0000, 16'hFFFF));
        pending_items.push_back(mk(0, 0, 32'sh0001_0000, 32'sh0001_0000, 16'h2000));
        pending_items.push_back(mk(0, 0, 32'sh0001_0000, 32'sh0001_0000, 16'h0001));
        pending_items.push_back(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                   32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h1555));
        pending_items.push_back(mk(32'sh8000_0000, 32'sh8000_0000,
                                   32'sh8000_0000, 32'sh8000_0000, 16'h0000));
        pending_items.push_back(mk(32'sh8000_0000, 32'sh7FFF_FFFF,
                                   32'sh7FFF_FFFF, 32'sh8000_0000, 16'h6000));
        pending_items.push_back(mk(32'sh0010_0000, -32'sh0010_0000,
                                   -32'sh0003_0000, 32'sh0002_0000, 16'h1000));
        pending_items.push_back(mk(32'sh0010_0000, -32'sh0010_0000,
                                   32'sh0003_0000, -32'sh0002_0000, 16'hA000));
        pending_items.push_back(mk(32'sh1234_5678, 32'shFEDC_BA98, 0, 0, 16'h7777));
        pending_items.push_back(mk(32'sh7FFF_0000, 0, 32'sh4000_0000, 0, 16'h0000));
        pending_items.push_back(mk(0, 32'sh8001_0000, 0, 32'sh4000_0000, 16'h8000));
        pending_items.push_back(mk(-1, -1, -1, -1, 16'hFFFF));
        pending_items.push_back(mk(1, 1, 1, 1, 16'h0001));
        // Random: mostly moderate sizes with full-range outliers.
        for (int n = 0; n < N_RANDOM; n++) begin
            it = mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                    16'($urandom));
            it.drain_first = (n == 60 || n == 200);
            pending_items.push_back(it);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0);
        @(posedge i_clk);
        while (start || expected_points.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("Run covered %0d hexagons and %0d points, including quadrant edges,",
                 n_accepted, n_points);
        $display("saturating extremes, mirrored sizes and drained pauses; %0d mismatches.",
                 n_errors);
        if (n_errors == 0 && expected_points.size() == 0)
            $display("** rotated_hexagon_vertices_core: PASSED **");
        else
            $display("** rotated_hexagon_vertices_core: FAILED **");
        $finish;
    end

endmodule
